### design/rtd_pkg.sv
// ----------------------------------------------------------------------------
// RTD solver package
// Shared widths, calibration constants and per-round constants of the
// platinum sensor resistance to temperature bisection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rtd_pkg;

   localparam int DEF_BISECTION_STEPS = 22;
   localparam int DEF_TEMP_FRAC_BITS  = 20;

   localparam int RES_W          = 16;
   localparam int TENTHS_W       = 13;
   localparam int TEMP_INT_BITS  = 10;
   localparam int MAG_W          = 56;
   localparam int V_W            = MAG_W + 1;
   localparam int HALF_W         = MAG_W / 2;
   localparam int NUM_ROUNDS     = 3;
   localparam int MEAS_SHIFT     = 44;
   localparam int OHMS_W         = 10;
   localparam int NOMINAL_OHMS   = 1000;
   localparam int TENTHS_PER_DEG = 10;
   localparam int RANGE_LOW_DEG  = 5;
   localparam int RANGE_HIGH_DEG = 380;
   localparam int TENTHS_MIN     = -50;
   localparam int TENTHS_MAX     = 3800;

   localparam logic signed [63:0] COEF_A_Q62   = 64'sd18023851366710610;
   localparam logic signed [63:0] COEF_B_Q72   = -64'sd2727145128200000;
   localparam logic signed [63:0] POLY_ONE_Q48 = 64'sd1 <<< 48;
   localparam logic [MAG_W-1:0]   COEF_C_MAG   = MAG_W'(64'd544048892200000);
   localparam logic               COEF_C_NEG   = 1'b1;

   // Each Horner round computes add + trunc(v * t / 2^(F + shift)).
   localparam int ROUND_SHIFT [NUM_ROUNDS] = '{24, 10, 14};
   localparam logic signed [V_W-1:0] ROUND_ADD [NUM_ROUNDS] = '{
      V_W'(COEF_B_Q72), V_W'(COEF_A_Q62), V_W'(POLY_ONE_Q48)
   };

endpackage

`default_nettype wire

### design/rtd_bisect_step.sv
// ----------------------------------------------------------------------------
// RTD bisection step
// One halving of the temperature interval: evaluates the cubic calibration
// polynomial at the midpoint in three pipelined Horner rounds, compares the
// scaled result with the measurement and selects the next interval.
// ----------------------------------------------------------------------------
`default_nettype none

module rtd_bisect_step
   import rtd_pkg::*;
#(
   parameter int TEMP_FRAC_BITS = DEF_TEMP_FRAC_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         en,
   input  logic                                         valid_i,
   input  logic signed [TEMP_FRAC_BITS+TEMP_INT_BITS-1:0] lo_i,
   input  logic signed [TEMP_FRAC_BITS+TEMP_INT_BITS-1:0] hi_i,
   input  logic signed [TEMP_FRAC_BITS+TEMP_INT_BITS-1:0] mid_i,
   input  logic [RES_W-1:0]                             res_i,
   output logic                                         valid_o,
   output logic signed [TEMP_FRAC_BITS+TEMP_INT_BITS-1:0] lo_o,
   output logic signed [TEMP_FRAC_BITS+TEMP_INT_BITS-1:0] hi_o,
   output logic signed [TEMP_FRAC_BITS+TEMP_INT_BITS-1:0] mid_o,
   output logic [RES_W-1:0]                             res_o
);

   localparam int T_W        = TEMP_FRAC_BITS + TEMP_INT_BITS;
   localparam int T_MAG_W    = T_W - 1;
   localparam int TL_W       = (T_MAG_W + 1) / 2;
   localparam int TH_W       = T_MAG_W - TL_W;
   localparam int HI_W       = MAG_W - HALF_W;
   localparam int PROD_W     = MAG_W + T_MAG_W;
   localparam int P1K_W      = MAG_W + OHMS_W;
   localparam int LAST_CTX   = 3 * NUM_ROUNDS + 1;
   localparam int LAST_STAGE = LAST_CTX + 1;

   typedef struct packed {
      logic signed [T_W-1:0] lo;
      logic signed [T_W-1:0] hi;
      logic signed [T_W-1:0] mid;
      logic signed [T_W-1:0] cand_down;
      logic signed [T_W-1:0] cand_up;
      logic [T_MAG_W-1:0]    t_mag;
      logic                  t_neg;
      logic [RES_W-1:0]      res;
   } step_ctx_type;

   step_ctx_type          ctx_in;
   step_ctx_type          ctx_ff [LAST_CTX+1];
   logic [LAST_STAGE:0]   valid_ff;
   logic signed [T_W-1:0] mid_abs;

   logic [MAG_W-1:0]      rmag_ff [NUM_ROUNDS];
   logic                  rneg_ff [NUM_ROUNDS];
   logic [P1K_W-1:0]      p1k_ff;
   logic                  pneg_ff;
   logic                  go_down;

   logic signed [T_W-1:0] out_lo_ff;
   logic signed [T_W-1:0] out_hi_ff;
   logic signed [T_W-1:0] out_mid_ff;
   logic [RES_W-1:0]      out_res_ff;

   always_comb begin
      mid_abs          = mid_i[T_W-1] ? -mid_i : mid_i;
      ctx_in.lo        = lo_i;
      ctx_in.hi        = hi_i;
      ctx_in.mid       = mid_i;
      ctx_in.cand_down = lo_i + ((mid_i - lo_i) >>> 1);
      ctx_in.cand_up   = mid_i + ((hi_i - mid_i) >>> 1);
      ctx_in.t_mag     = mid_abs[T_MAG_W-1:0];
      ctx_in.t_neg     = mid_i[T_W-1];
      ctx_in.res       = res_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAST_STAGE-1:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= ctx_in;
         for (int s = 1; s <= LAST_CTX; s++) begin
            ctx_ff[s] <= ctx_ff[s-1];
         end
      end
   end

   for (genvar m = 0; m < NUM_ROUNDS; m++) begin : g_round
      localparam int SHIFT = TEMP_FRAC_BITS + ROUND_SHIFT[m];
      localparam logic signed [V_W-1:0] ADD_K = ROUND_ADD[m];

      logic [MAG_W-1:0]       a_mag;
      logic                   a_neg;
      logic [HALF_W+TL_W-1:0] pp_ll_ff;
      logic [HALF_W+TH_W-1:0] pp_lh_ff;
      logic [HI_W+TL_W-1:0]   pp_hl_ff;
      logic [HI_W+TH_W-1:0]   pp_hh_ff;
      logic                   neg_a_ff;
      logic                   neg_b_ff;
      logic [PROD_W-1:0]      prod_ff;
      logic [PROD_W-1:0]      prod_sh;
      logic [MAG_W-1:0]       term;
      logic signed [V_W-1:0]  v_pos;
      logic signed [V_W-1:0]  v_flip;

      if (m == 0) begin : g_first
         assign a_mag = COEF_C_MAG;
         assign a_neg = COEF_C_NEG;
      end else begin : g_next
         assign a_mag = rmag_ff[m-1];
         assign a_neg = rneg_ff[m-1];
      end

      always_comb begin
         prod_sh = prod_ff >> SHIFT;
         term    = prod_sh[MAG_W-1:0];
         v_pos   = neg_b_ff ? ADD_K - $signed({1'b0, term})
                            : ADD_K + $signed({1'b0, term});
         v_flip  = neg_b_ff ? $signed({1'b0, term}) - ADD_K
                            : -ADD_K - $signed({1'b0, term});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pp_ll_ff   <= (HALF_W+TL_W)'(a_mag[HALF_W-1:0])
                          * (HALF_W+TL_W)'(ctx_ff[3*m].t_mag[TL_W-1:0]);
            pp_lh_ff   <= (HALF_W+TH_W)'(a_mag[HALF_W-1:0])
                          * (HALF_W+TH_W)'(ctx_ff[3*m].t_mag[T_MAG_W-1:TL_W]);
            pp_hl_ff   <= (HI_W+TL_W)'(a_mag[MAG_W-1:HALF_W])
                          * (HI_W+TL_W)'(ctx_ff[3*m].t_mag[TL_W-1:0]);
            pp_hh_ff   <= (HI_W+TH_W)'(a_mag[MAG_W-1:HALF_W])
                          * (HI_W+TH_W)'(ctx_ff[3*m].t_mag[T_MAG_W-1:TL_W]);
            neg_a_ff   <= a_neg ^ ctx_ff[3*m].t_neg;
            prod_ff    <= PROD_W'(pp_ll_ff)
                          + (PROD_W'(pp_lh_ff) << TL_W)
                          + (PROD_W'(pp_hl_ff) << HALF_W)
                          + (PROD_W'(pp_hh_ff) << (HALF_W + TL_W));
            neg_b_ff   <= neg_a_ff;
            rmag_ff[m] <= v_pos[V_W-1] ? v_flip[MAG_W-1:0] : v_pos[MAG_W-1:0];
            rneg_ff[m] <= v_pos[V_W-1];
         end
      end
   end

   // A negative polynomial value can never exceed the measurement.
   assign go_down = !pneg_ff &&
                    (p1k_ff > P1K_W'({ctx_ff[LAST_CTX].res, {MEAS_SHIFT{1'b0}}}));

   always_ff @(posedge clock) begin
      if (en) begin
         p1k_ff     <= P1K_W'(rmag_ff[NUM_ROUNDS-1]) * P1K_W'(NOMINAL_OHMS);
         pneg_ff    <= rneg_ff[NUM_ROUNDS-1];
         out_lo_ff  <= go_down ? ctx_ff[LAST_CTX].lo : ctx_ff[LAST_CTX].mid;
         out_hi_ff  <= go_down ? ctx_ff[LAST_CTX].mid : ctx_ff[LAST_CTX].hi;
         out_mid_ff <= go_down ? ctx_ff[LAST_CTX].cand_down : ctx_ff[LAST_CTX].cand_up;
         out_res_ff <= ctx_ff[LAST_CTX].res;
      end
   end

   assign valid_o = valid_ff[LAST_STAGE];
   assign lo_o    = out_lo_ff;
   assign hi_o    = out_hi_ff;
   assign mid_o   = out_mid_ff;
   assign res_o   = out_res_ff;

endmodule

`default_nettype wire

### design/rtd_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// RTD resistance to temperature solver
// Each accepted word passes through BISECTION_STEPS bisection steps, the sum,
// times-ten and rounding registers and the output register; each step is a
// 12-stage polynomial pipe. Throughput is one word per cycle; a skid word
// absorbs the first result meeting a stalled output; then the pipe and input hold.
// Reset clears only valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rtd_resistance_to_temperature
   import rtd_pkg::*;
#(
   parameter int BISECTION_STEPS = DEF_BISECTION_STEPS,
   parameter int TEMP_FRAC_BITS  = DEF_TEMP_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [RES_W-1:0]           req_resistance_q4,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TENTHS_W-1:0] rsp_temperature_tenths
);

   localparam int T_W        = TEMP_FRAC_BITS + TEMP_INT_BITS;
   localparam int SUM_W      = T_W + 1;
   localparam int P10_W      = T_W + 4;
   localparam int DIV_SHIFT  = TEMP_FRAC_BITS + 1;

   localparam logic signed [63:0] LO_WIDE  = -(64'(RANGE_LOW_DEG) <<< TEMP_FRAC_BITS);
   localparam logic signed [63:0] HI_WIDE  = 64'(RANGE_HIGH_DEG) <<< TEMP_FRAC_BITS;
   localparam logic signed [63:0] MID_WIDE = LO_WIDE + ((HI_WIDE - LO_WIDE) >>> 1);
   localparam logic signed [63:0] BIAS_WIDE = (64'sd1 <<< DIV_SHIFT) - 64'sd1;

   localparam logic signed [T_W-1:0]   LO_INIT  = LO_WIDE[T_W-1:0];
   localparam logic signed [T_W-1:0]   HI_INIT  = HI_WIDE[T_W-1:0];
   localparam logic signed [T_W-1:0]   MID_INIT = MID_WIDE[T_W-1:0];
   localparam logic signed [P10_W-1:0] TRUNC_BIAS = BIAS_WIDE[P10_W-1:0];

   logic                  en;
   logic                  chain_valid [BISECTION_STEPS+1];
   logic signed [T_W-1:0] chain_lo    [BISECTION_STEPS+1];
   logic signed [T_W-1:0] chain_hi    [BISECTION_STEPS+1];
   logic signed [T_W-1:0] chain_mid   [BISECTION_STEPS+1];
   logic [RES_W-1:0]      chain_res   [BISECTION_STEPS+1];

   logic [2:0]              fin_valid_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [P10_W-1:0] p10_ff;
   logic signed [P10_W-1:0] biased;
   logic signed [P10_W-1:0] quotient;
   logic [TENTHS_W-1:0]     tenths_ff;
   logic                    p_valid;

   logic                    rsp_valid_ff;
   logic [TENTHS_W-1:0]     rsp_data_ff;
   logic                    skid_valid_ff;
   logic [TENTHS_W-1:0]     skid_data_ff;
   logic                    rsp_free;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   assign chain_valid[0] = req_valid;
   assign chain_lo[0]    = LO_INIT;
   assign chain_hi[0]    = HI_INIT;
   assign chain_mid[0]   = MID_INIT;
   assign chain_res[0]   = req_resistance_q4;

   for (genvar k = 0; k < BISECTION_STEPS; k++) begin : g_step
      rtd_bisect_step #(
         .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (chain_valid[k]),
         .lo_i    (chain_lo[k]),
         .hi_i    (chain_hi[k]),
         .mid_i   (chain_mid[k]),
         .res_i   (chain_res[k]),
         .valid_o (chain_valid[k+1]),
         .lo_o    (chain_lo[k+1]),
         .hi_o    (chain_hi[k+1]),
         .mid_o   (chain_mid[k+1]),
         .res_o   (chain_res[k+1])
      );
   end

   // An arithmetic shift rounds toward minus infinity, so negative values get a bias.
   always_comb begin
      biased   = p10_ff + (p10_ff[P10_W-1] ? TRUNC_BIAS : '0);
      quotient = biased >>> DIV_SHIFT;
   end

   assign p_valid = fin_valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= '0;
      end else if (en) begin
         fin_valid_ff <= {fin_valid_ff[1:0], chain_valid[BISECTION_STEPS]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff    <= SUM_W'(chain_lo[BISECTION_STEPS]) + SUM_W'(chain_hi[BISECTION_STEPS]);
         p10_ff    <= P10_W'(sum_ff) * P10_W'(TENTHS_PER_DEG);
         tenths_ff <= quotient[TENTHS_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= p_valid;
         end
      end else if (!skid_valid_ff && p_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : tenths_ff;
      end else if (!skid_valid_ff) begin
         skid_data_ff <= tenths_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_tenths = rsp_data_ff;

   a_skid_implies_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("Skid word held while the output register is empty.");

   a_skid_kept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("Skid word lost while the output is stalled.");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature_tenths >= TENTHS_MIN &&
                     rsp_temperature_tenths <= TENTHS_MAX))
      else $error("Temperature result outside the solver range.");

endmodule

`default_nettype wire
